[rtl/rlb_pkg.sv]
// ----------------------------------------------------------------------------
// rlb_pkg: shared types and constants for the RGB LED mode blinker
// Event and configuration structs, command and mode codes, colour decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlb_pkg;

  localparam int unsigned SleepCountBits = 24;
  localparam int unsigned SleepMsW       = 24;
  localparam int unsigned PeriodW        = 16;
  localparam int unsigned CfgIdxW        = 3;

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindMode  = 2'd1,
    KindSleep = 2'd2,
    KindPulse = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ModeOff   = 2'd0,
    ModeOn    = 2'd1,
    ModeBlink = 2'd2,
    ModeFast  = 2'd3
  } mode_e;

  localparam logic [CfgIdxW-1:0] CfgSlowHalf  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFastHalf  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPulseLen  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgActiveLow = 3'd3;

  localparam logic [2:0] ColorRed    = 3'd0;
  localparam logic [2:0] ColorGreen  = 3'd1;
  localparam logic [2:0] ColorBlue   = 3'd2;
  localparam logic [2:0] ColorYellow = 3'd3;

  localparam logic [PeriodW-1:0] SlowHalfRst  = 16'd1000;
  localparam logic [PeriodW-1:0] FastHalfRst  = 16'd250;
  localparam logic [PeriodW-1:0] PulseLenRst  = 16'd250;
  localparam logic               ActiveLowRst = 1'b1;

  typedef struct packed {
    kind_e               kind;
    mode_e               mode;
    logic [2:0]          color;
    logic [SleepMsW-1:0] sleep_ms;
  } event_t;

  typedef struct packed {
    logic [PeriodW-1:0] slow_half;
    logic [PeriodW-1:0] fast_half;
    logic [PeriodW-1:0] pulse_len;
    logic               active_low;
  } cfg_t;

  // bit 0 red, bit 1 green, bit 2 blue
  function automatic logic [2:0] color_bits(input logic [2:0] c);
    logic [2:0] bits;
    unique case (c)
      ColorRed:    bits = 3'b001;
      ColorGreen:  bits = 3'b010;
      ColorBlue:   bits = 3'b100;
      ColorYellow: bits = 3'b011;
      default:     bits = 3'b000;
    endcase
    return bits;
  endfunction

endpackage

[rtl/rlb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rlb_cfg_regs: configuration register bank
// Holds blink half periods, pulse length and pin polarity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rlb_pkg::PeriodW-1:0]   cfg_data_i,
  output rlb_pkg::cfg_t                 cfg_o
);
  import rlb_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_half  <= SlowHalfRst;
      cfg_q.fast_half  <= FastHalfRst;
      cfg_q.pulse_len  <= PulseLenRst;
      cfg_q.active_low <= ActiveLowRst;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == CfgSlowHalf) begin
        cfg_q.slow_half <= cfg_data_i;
      end
      if (cfg_idx_i == CfgFastHalf) begin
        cfg_q.fast_half <= cfg_data_i;
      end
      if (cfg_idx_i == CfgPulseLen) begin
        cfg_q.pulse_len <= cfg_data_i;
      end
      if (cfg_idx_i == CfgActiveLow) begin
        cfg_q.active_low <= cfg_data_i[0];
      end
    end
  end

endmodule

[rtl/rlb_in_stage.sv]
// ----------------------------------------------------------------------------
// rlb_in_stage: input event register
// Captures one event beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rlb_pkg::event_t ev_i,
  output logic            valid_o,
  input  logic            ready_i,
  output rlb_pkg::event_t ev_o
);
  import rlb_pkg::*;

  logic   valid_q;
  event_t ev_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign ev_o    = ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ev_q <= ev_i;
    end
  end

endmodule

[rtl/rlb_core.sv]
// ----------------------------------------------------------------------------
// rlb_core: LED state update and result register
// Applies one event to mode, blink, sleep and pulse state, registers levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlb_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  rlb_pkg::event_t ev_i,
  input  rlb_pkg::cfg_t   cfg_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            red_level_o,
  output logic            green_level_o,
  output logic            blue_level_o,
  output logic            pulse_showing_o
);
  import rlb_pkg::*;

  localparam logic [32:0] SleepMaxWide = (33'd1 << SleepCountBits) - 33'd1;

  mode_e                     mode_q, mode_d;
  logic [2:0]                color_q, color_d;
  logic                      phase_q, phase_d;
  logic [PeriodW-1:0]        count_q, count_d;
  logic                      sleep_armed_q, sleep_armed_d;
  logic [SleepCountBits-1:0] sleep_left_q, sleep_left_d;
  logic                      pulse_armed_q, pulse_armed_d;
  logic [PeriodW-1:0]        pulse_left_q, pulse_left_d;
  logic [2:0]                pulse_hue_q, pulse_hue_d;

  logic                      out_valid_q;
  logic [2:0]                level_q, level_d;
  logic                      showing_q, showing_d;

  logic                      take;
  logic [SleepCountBits-1:0] sleep_dec;
  logic [PeriodW-1:0]        pulse_dec;
  logic [PeriodW:0]          count_inc;
  logic [PeriodW-1:0]        period;
  logic [32:0]               ms_wide;
  logic [2:0]                lit;

  assign ready_o = !out_valid_q || out_ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    mode_d        = mode_q;
    color_d       = color_q;
    phase_d       = phase_q;
    count_d       = count_q;
    sleep_armed_d = sleep_armed_q;
    sleep_left_d  = sleep_left_q;
    pulse_armed_d = pulse_armed_q;
    pulse_left_d  = pulse_left_q;
    pulse_hue_d   = pulse_hue_q;
    sleep_dec     = sleep_left_q - {{(SleepCountBits-1){1'b0}}, 1'b1};
    pulse_dec     = pulse_left_q - {{(PeriodW-1){1'b0}}, 1'b1};
    count_inc     = {1'b0, count_q} + {{PeriodW{1'b0}}, 1'b1};
    period        = cfg_i.slow_half;
    ms_wide       = {{(33-SleepMsW){1'b0}}, ev_i.sleep_ms};

    unique case (ev_i.kind)
      KindTick: begin
        if (sleep_armed_q) begin
          sleep_left_d = sleep_dec;
          if (sleep_dec == '0) begin
            sleep_armed_d = 1'b0;
            mode_d        = ModeOff;
            phase_d       = 1'b0;
            pulse_armed_d = 1'b0;
            pulse_left_d  = '0;
          end
        end
        if (pulse_armed_d) begin
          pulse_left_d = pulse_dec;
          if (pulse_dec == '0) begin
            pulse_armed_d = 1'b0;
          end
        end
        if (mode_d == ModeBlink || mode_d == ModeFast) begin
          period = (mode_d == ModeBlink) ? cfg_i.slow_half : cfg_i.fast_half;
          if (count_inc >= {1'b0, period}) begin
            phase_d = !phase_d;
            count_d = '0;
          end else begin
            count_d = count_inc[PeriodW-1:0];
          end
        end
      end
      KindMode: begin
        if (ev_i.mode != mode_q) begin
          phase_d = (ev_i.mode != ModeOff);
        end
        mode_d  = ev_i.mode;
        color_d = ev_i.color;
        count_d = '0;
      end
      KindSleep: begin
        if (ev_i.sleep_ms == '0) begin
          sleep_armed_d = 1'b0;
          sleep_left_d  = '0;
        end else begin
          sleep_armed_d = 1'b1;
          if (ms_wide > SleepMaxWide) begin
            sleep_left_d = SleepMaxWide[SleepCountBits-1:0];
          end else begin
            sleep_left_d = ms_wide[SleepCountBits-1:0];
          end
        end
        count_d = '0;
      end
      KindPulse: begin
        pulse_hue_d   = ev_i.color;
        pulse_left_d  = cfg_i.pulse_len;
        pulse_armed_d = (cfg_i.pulse_len != '0);
        count_d       = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    showing_d = 1'b0;
    priority if (pulse_armed_d) begin
      lit       = color_bits(pulse_hue_d);
      showing_d = 1'b1;
    end else if (mode_d == ModeOn) begin
      lit = color_bits(color_d);
    end else if ((mode_d == ModeBlink || mode_d == ModeFast) && phase_d) begin
      lit = color_bits(color_d);
    end else begin
      lit = 3'b000;
    end
    level_d = lit ^ {3{cfg_i.active_low}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeOff;
      color_q       <= ColorRed;
      phase_q       <= 1'b0;
      count_q       <= '0;
      sleep_armed_q <= 1'b0;
      sleep_left_q  <= '0;
      pulse_armed_q <= 1'b0;
      pulse_left_q  <= '0;
      pulse_hue_q   <= ColorRed;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        mode_q        <= mode_d;
        color_q       <= color_d;
        phase_q       <= phase_d;
        count_q       <= count_d;
        sleep_armed_q <= sleep_armed_d;
        sleep_left_q  <= sleep_left_d;
        pulse_armed_q <= pulse_armed_d;
        pulse_left_q  <= pulse_left_d;
        pulse_hue_q   <= pulse_hue_d;
      end
      if (ready_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q   <= level_d;
      showing_q <= showing_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_level_o     = level_q[0];
  assign green_level_o   = level_q[1];
  assign blue_level_o    = level_q[2];
  assign pulse_showing_o = showing_q;

`ifndef SYNTH
  a_sleep_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sleep_armed_q |-> sleep_left_q != '0)
    else $error("armed sleep timer holds zero");
  a_sleep_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sleep_armed_q |-> sleep_left_q == '0)
    else $error("idle sleep timer holds a count");
  a_pulse_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_armed_q |-> pulse_left_q != '0)
    else $error("armed pulse holds zero length");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '1)
    else $error("blink count reached its ceiling");
`endif

endmodule

[rtl/rgb_led_mode_blinker.sv]
// ----------------------------------------------------------------------------
// Path: an accepted event beat is registered in the input register, then applied
// by the core into the result register; a held result can stall it in between.
// Throughput: one event per cycle while the result channel is not held; the input
// register takes one more event while a result is held, then stalls as well.
// Reset: all mode, blink, sleep and pulse state clears and the configuration
// returns to its defaults at once; no result is pending after reset.
// ----------------------------------------------------------------------------
// rgb_led_mode_blinker: RGB status LED controller with blink, sleep and pulse
// Turns tick and command events into pin levels for a three-pin RGB LED.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_led_mode_blinker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rlb_pkg::PeriodW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [1:0]                    mode_i,
  input  logic [2:0]                    color_i,
  input  logic [rlb_pkg::SleepMsW-1:0]  sleep_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          red_level_o,
  output logic                          green_level_o,
  output logic                          blue_level_o,
  output logic                          pulse_showing_o
);
  import rlb_pkg::*;

  cfg_t   cfg;
  event_t ev_in;
  event_t ev_reg;
  logic   ev_valid;
  logic   core_ready;

  assign ev_in.kind     = kind_e'(kind_i);
  assign ev_in.mode     = mode_e'(mode_i);
  assign ev_in.color    = color_i;
  assign ev_in.sleep_ms = sleep_ms_i;

  rlb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rlb_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .ev_i    (ev_in),
    .valid_o (ev_valid),
    .ready_i (core_ready),
    .ev_o    (ev_reg)
  );

  rlb_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (ev_valid),
    .ready_o         (core_ready),
    .ev_i            (ev_reg),
    .cfg_i           (cfg),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_level_o     (red_level_o),
    .green_level_o   (green_level_o),
    .blue_level_o    (blue_level_o),
    .pulse_showing_o (pulse_showing_o)
  );

endmodule
